// ----- rtl/cke_pkg.sv -----
`default_nettype none
package cke_pkg;

  localparam int ByteW   = 8;
  localparam int IntW    = 64;
  localparam int RunBytes = 10;
  localparam int CntW    = 4;
  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;

  localparam logic [1:0] REQ_BOOL = 2'd0;
  localparam logic [1:0] REQ_INT  = 2'd1;
  localparam logic [1:0] REQ_CHAR = 2'd2;
  localparam logic [1:0] REQ_END  = 2'd3;

  localparam logic [7:0] TAG_FALSE = 8'd2;
  localparam logic [7:0] TAG_TRUE  = 8'd3;
  localparam logic [7:0] TAG_INT   = 8'd4;
  localparam logic [7:0] TAG_STR   = 8'd5;
  localparam logic [7:0] LEN_POS   = 8'h80;
  localparam logic [7:0] LEN_NEG   = 8'd127;
  localparam logic [7:0] SIGN_NEG  = 8'hFF;

  // One run of key bytes, first byte in the top lane.
  typedef struct packed {
    logic [RunBytes*ByteW-1:0] bytes;
    logic [CntW-1:0]           cnt;
  } desc_t;

  function automatic logic [7:0] prio_of(input logic [7:0] c);
    logic [7:0] p;
    logic [7:0] d;
    p = 8'd0;
    d = 8'd0;
    if (c[7]) begin
      p = c;
    end else if (c >= 8'd48 && c <= 8'd57) begin
      p = c - 8'd11;
    end else if (c >= 8'd97 && c <= 8'd122) begin
      d = c - 8'd97;
      p = {d[6:0], 1'b0} + 8'd47;
    end else if (c >= 8'd65 && c <= 8'd90) begin
      d = c - 8'd65;
      p = {d[6:0], 1'b0} + 8'd48;
    end else begin
      case (c)
        8'h09: p = 8'd1;
        8'h0A: p = 8'd2;
        8'h0D: p = 8'd3;
        8'h20: p = 8'd4;
        8'h60: p = 8'd5;
        8'h5E: p = 8'd6;
        8'h5F: p = 8'd7;
        8'h2D: p = 8'd8;
        8'h2C: p = 8'd9;
        8'h3B: p = 8'd10;
        8'h3A: p = 8'd11;
        8'h21: p = 8'd12;
        8'h3F: p = 8'd13;
        8'h2E: p = 8'd14;
        8'h27: p = 8'd15;
        8'h22: p = 8'd16;
        8'h28: p = 8'd17;
        8'h29: p = 8'd18;
        8'h5B: p = 8'd19;
        8'h5D: p = 8'd20;
        8'h7B: p = 8'd21;
        8'h7D: p = 8'd22;
        8'h40: p = 8'd23;
        8'h2A: p = 8'd24;
        8'h2F: p = 8'd25;
        8'h5C: p = 8'd26;
        8'h26: p = 8'd27;
        8'h23: p = 8'd28;
        8'h25: p = 8'd29;
        8'h2B: p = 8'd30;
        8'h3C: p = 8'd31;
        8'h3D: p = 8'd32;
        8'h3E: p = 8'd33;
        8'h7C: p = 8'd34;
        8'h7E: p = 8'd35;
        8'h24: p = 8'd36;
        default: p = 8'd0;
      endcase
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cke_if.sv -----
`default_nettype none
interface cke_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic               bool_value;
  logic signed [63:0] int_value;
  logic [7:0]         char_byte;

  modport source (output valid, req_type, bool_value, int_value, char_byte, input ready);
  modport sink (input valid, req_type, bool_value, int_value, char_byte, output ready);
endinterface

interface cke_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink (input valid, out_byte, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/cke_front.sv -----
`default_nettype none
module cke_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  cke_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output cke_pkg::desc_t     q_desc
);
  import cke_pkg::*;

  logic        in_string_r;
  logic        in_string_nxt;
  logic [63:0] v;
  logic        neg;
  logic [7:0]  sgn;
  logic [3:0]  skip;
  logic        run;
  logic [3:0]  nb;
  logic [63:0] v_sh;
  logic [7:0]  len_b;
  logic [7:0]  prio;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    v    = 64'(unsigned'(in_ch.int_value));
    neg  = v[63];
    sgn  = neg ? SIGN_NEG : 8'h00;
    skip = 4'd0;
    run  = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (run && v[63-8*i -: 8] == sgn) begin
        skip = skip + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    if (neg && skip != 4'd0) begin
      skip = skip - 4'd1;
    end
    nb    = 4'd8 - skip;
    v_sh  = v << {skip, 3'b000};
    len_b = neg ? (LEN_NEG - {4'd0, nb}) : (LEN_POS | {4'd0, nb});
  end

  assign prio = prio_of(in_ch.char_byte);

  always_comb begin
    q_desc        = '0;
    in_string_nxt = in_string_r;
    case (in_ch.req_type)
      REQ_BOOL: begin
        q_desc.bytes  = {(in_ch.bool_value ? TAG_TRUE : TAG_FALSE), 72'd0};
        q_desc.cnt    = 4'd1;
        in_string_nxt = 1'b0;
      end
      REQ_INT: begin
        q_desc.bytes  = {TAG_INT, len_b, v_sh};
        q_desc.cnt    = nb + 4'd2;
        in_string_nxt = 1'b0;
      end
      REQ_CHAR: begin
        if (in_string_r) begin
          q_desc.bytes = {prio, 72'd0};
          q_desc.cnt   = 4'd1;
        end else begin
          q_desc.bytes = {TAG_STR, prio, 64'd0};
          q_desc.cnt   = 4'd2;
        end
        in_string_nxt = 1'b1;
      end
      REQ_END: begin
        if (in_string_r) begin
          q_desc.bytes = 80'd0;
          q_desc.cnt   = 4'd1;
        end else begin
          q_desc.bytes = {TAG_STR, 72'd0};
          q_desc.cnt   = 4'd2;
        end
        in_string_nxt = 1'b0;
      end
      default: begin
        q_desc        = '0;
        in_string_nxt = in_string_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_string_r <= 1'b0;
    end else if (q_push) begin
      in_string_r <= in_string_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cke_fifo.sv -----
`default_nettype none
module cke_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cke_pkg::desc_t push_desc,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output cke_pkg::desc_t      head
);
  import cke_pkg::*;

  desc_t              mem_r [QDepth];
  logic [QPtrW-1:0]   wr_r, wr_nxt;
  logic [QPtrW-1:0]   rd_r, rd_nxt;
  logic [QPtrW:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPtrW+1)'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPtrW'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPtrW'(1) : rd_r;
    cnt_nxt = cnt_r + {{QPtrW{1'b0}}, push} - {{QPtrW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cke_back.sv -----
`default_nettype none
module cke_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire cke_pkg::desc_t q_head,
  output logic                q_pop,
  cke_out_if.source           out_ch
);
  import cke_pkg::*;

  logic [71:0] sh_r, sh_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        last_r, last_nxt;
  logic        adv;

  assign adv   = !ov_r || out_ch.ready;
  assign q_pop = adv && (cnt_r == 4'd0) && q_valid;

  assign out_ch.valid       = ov_r;
  assign out_ch.out_byte    = ob_r;
  assign out_ch.last_of_run = last_r;

  always_comb begin
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    last_nxt = last_r;
    if (adv) begin
      if (cnt_r != 4'd0) begin
        ob_nxt   = sh_r[71:64];
        sh_nxt   = {sh_r[63:0], 8'd0};
        cnt_nxt  = cnt_r - 4'd1;
        last_nxt = (cnt_r == 4'd1);
        ov_nxt   = 1'b1;
      end else if (q_valid) begin
        ob_nxt   = q_head.bytes[79:72];
        sh_nxt   = q_head.bytes[71:0];
        cnt_nxt  = q_head.cnt - 4'd1;
        last_nxt = (q_head.cnt == 4'd1);
        ov_nxt   = 1'b1;
      end else begin
        ov_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    ob_r   <= ob_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/collation_key_encoder_core.sv -----
// Order-preserving key encoder.
// in_ch: one typed request per handshake (boolean, 64-bit integer, string byte,
//   string end). out_ch: one key byte per handshake, last_of_run set on the
//   final byte a request produces.
// Each request yields 1 to 10 key bytes: boolean 1, integer 2 to 10, string
//   byte 1 or 2 (tag before the first byte), string end 1 or 2.
// With the queue empty, an accepted request is first written into the queue
//   and then loaded into the output register, which makes its first byte valid.
// Throughput: one key byte per cycle while out_ch.ready is high, set by the
//   output register. Requests are classified on acceptance and wait in a
//   4-entry queue, so in_ch keeps accepting while earlier runs drain.
// Receiver stall: the output byte holds; once the queue fills, in_ch.ready
//   drops until the back end pops an entry.
// Reset (rst_n low, synchronous): queue emptied, output invalid, string state
//   cleared.
`default_nettype none
module collation_key_encoder_core (
  input  wire logic clk,
  input  wire logic rst_n,
  cke_in_if.sink    in_ch,
  cke_out_if.source out_ch
);
  import cke_pkg::*;

  desc_t push_desc;
  desc_t head;
  logic  push;
  logic  full;
  logic  pop;
  logic  not_empty;

  cke_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (full),
    .q_push (push),
    .q_desc (push_desc)
  );

  cke_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  cke_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (not_empty),
    .q_head  (head),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

// ----- rtl/cke_checker.sv -----
`default_nettype none
module cke_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);
  import cke_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("output payload changed while stalled");

  a_run_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) ##1 (out_valid && !out_last)
    |-> (out_byte == TAG_INT || out_byte == TAG_STR))
    else $error("multi-byte run does not start with a tag");

endmodule

bind collation_key_encoder_core cke_checker u_cke_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_of_run)
);
`default_nettype wire
